@@ design/bta_pkg.sv @@
// package for the buddy tree allocator: sizes, sequencer states, ram write port, helpers
package bta_pkg;

	localparam int POOL_SLOTS = 1024;
	localparam int LOG_POOL   = $clog2(POOL_SLOTS);
	localparam int TREE_NODES = 2 * POOL_SLOTS - 1;
	localparam int IDX_W      = $clog2(TREE_NODES);
	localparam int VAL_W      = LOG_POOL + 1;
	localparam int LVL_W      = $clog2(LOG_POOL + 1);
	localparam int WANT_W     = 11;
	localparam int OFS_W      = 10;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DESC,
		ST_MARK,
		ST_ASC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] data;
	} wr_port_t;

	// ceiling log2 of a request of at least one slot
	function automatic logic [LVL_W-1:0] want_log2(input logic [WANT_W-1:0] want);
		logic [WANT_W-1:0] v;
		logic [LVL_W-1:0]  r;
		v = want - WANT_W'(1);
		r = '0;
		for (int i = 0; i < WANT_W; i++) begin
			if (v[i]) begin
				r = LVL_W'(i + 1);
			end
		end
		return r;
	endfunction

	// tree depth of a node: floor log2 of index plus one
	function automatic logic [LVL_W-1:0] node_depth(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] v;
		logic [LVL_W-1:0] r;
		v = idx + IDX_W'(1);
		r = '0;
		for (int i = 0; i < IDX_W; i++) begin
			if (v[i]) begin
				r = LVL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ design/bta_tree_ram.sv @@
// tree node memory: one write port, one read port with registered read data
module bta_tree_ram (
	input  logic                         clk,
	input  bta_pkg::wr_port_t            wr,
	input  logic [bta_pkg::IDX_W-1:0]    rd_addr,
	output logic [bta_pkg::VAL_W-1:0]    rd_data
);
	import bta_pkg::*;

	logic [VAL_W-1:0] mem_q [TREE_NODES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ design/buddy_tree_allocate.sv @@
// top level of the buddy tree allocator: request sequencer, tree walk and result register
//
//  channel   direction  handshake               payload
//  request   in         in_valid / in_stall     slots_wanted[10:0]
//  result    out        out_valid / out_stall   granted, slot_offset[9:0]
//
// after reset the node ram is swept once, one node a cycle, over all 2047 nodes (2*POOL_SLOTS-1),
// writing each node its subtree size; in_stall stays high during the sweep
// an accepted request holds the sequencer until its result is loaded: one ram read per level
// down and one per level up, each bound by the single ram read port with registered data;
// zero or oversized requests go straight to finish, no-room requests after the root check
// the result register frees the sequencer, so the next request is taken while a result
// waits; a new result waits in its finish state while out_stall holds the old one
module buddy_tree_allocate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bta_pkg::WANT_W-1:0]  slots_wanted,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        granted,
	output logic [bta_pkg::OFS_W-1:0]   slot_offset
);
	import bta_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] node_q;
	logic [LVL_W-1:0] lvl_q;
	logic [LVL_W-1:0] need_log_q;
	logic [VAL_W-1:0] cur_q;
	logic             res_grant_q;
	logic [OFS_W-1:0] res_ofs_q;
	logic             out_valid_q;
	logic             granted_q;
	logic [OFS_W-1:0] slot_offset_q;

	wr_port_t         wr;
	logic [IDX_W-1:0] rd_addr;
	logic [VAL_W-1:0] rd_data;

	// shared walk datapath
	logic             req_bad;
	logic [VAL_W-1:0] need;
	logic [IDX_W-1:0] left;
	logic [IDX_W-1:0] next_node;
	logic [LVL_W-1:0] lvl_next;
	logic [IDX_W-1:0] parent;
	logic [VAL_W-1:0] run_max;
	logic             out_free;
	logic [31:0]      ofs_full;

	bta_tree_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	function automatic logic [IDX_W-1:0] sibling(input logic [IDX_W-1:0] n);
		// left children have odd index
		return n[0] ? n + IDX_W'(1) : n - IDX_W'(1);
	endfunction

	assign req_bad   = (slots_wanted == '0) || (32'(slots_wanted) > 32'(POOL_SLOTS));
	assign need      = VAL_W'(1) << need_log_q;
	// in descent rd_data is the left child of node_q
	assign left      = (node_q << 1) + IDX_W'(1);
	assign next_node = (rd_data >= need) ? left : left + IDX_W'(1);
	assign lvl_next  = lvl_q - LVL_W'(1);
	// in ascent rd_data is the sibling of node_q
	assign parent    = (node_q - IDX_W'(1)) >> 1;
	assign run_max   = (rd_data > cur_q) ? rd_data : cur_q;
	assign out_free  = !out_valid_q || !out_stall;
	// first slot: (node+1) * size - pool, size a power of two
	assign ofs_full  = ((32'(node_q) + 32'd1) << need_log_q) - 32'(POOL_SLOTS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_W'(TREE_NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = req_bad ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (rd_data < need) begin
					state_d = ST_FINISH;
				end else if (need_log_q == LVL_W'(LOG_POOL)) begin
					state_d = ST_MARK;
				end else begin
					state_d = ST_DESC;
				end
			end
			ST_DESC: begin
				if (lvl_next == need_log_q) begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				state_d = (node_q == '0) ? ST_FINISH : ST_ASC;
			end
			ST_ASC: begin
				if (parent == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// ram port control
	always_comb begin
		wr      = '0;
		rd_addr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr.we   = 1'b1;
				wr.addr = clr_q;
				wr.data = VAL_W'(POOL_SLOTS) >> node_depth(clr_q);
			end
			ST_IDLE: begin
				rd_addr = '0;
			end
			ST_CHECK: begin
				rd_addr = IDX_W'(1);
			end
			ST_DESC: begin
				// fetch left child of the node chosen this cycle
				rd_addr = (next_node << 1) + IDX_W'(1);
			end
			ST_MARK: begin
				wr.we   = 1'b1;
				wr.addr = node_q;
				wr.data = '0;
				rd_addr = sibling(node_q);
			end
			ST_ASC: begin
				wr.we   = 1'b1;
				wr.addr = parent;
				wr.data = run_max;
				rd_addr = sibling(parent);
			end
			ST_FINISH: begin
				rd_addr = '0;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				need_log_q  <= want_log2(slots_wanted);
				node_q      <= '0;
				lvl_q       <= LVL_W'(LOG_POOL);
				res_grant_q <= 1'b0;
				res_ofs_q   <= '0;
			end
			ST_DESC: begin
				node_q <= next_node;
				lvl_q  <= lvl_next;
			end
			ST_MARK: begin
				cur_q       <= '0;
				res_grant_q <= 1'b1;
				res_ofs_q   <= ofs_full[OFS_W-1:0];
			end
			ST_ASC: begin
				node_q <= parent;
				cur_q  <= run_max;
			end
			ST_FINISH: begin
				if (out_free) begin
					granted_q     <= res_grant_q;
					slot_offset_q <= res_ofs_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign slot_offset = slot_offset_q;

	// descent never goes below the requested block size
	a_desc_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DESC) |-> (lvl_q > need_log_q))
		else $error("descent passed the requested level");

	// the ascent never sits on the root
	a_asc_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ASC) |-> (node_q != '0))
		else $error("ascent reached the root without finishing");

	// a granted block starts on a boundary of its own size
	a_ofs_align: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && res_grant_q) |->
		((32'(res_ofs_q) & ((32'd1 << need_log_q) - 32'd1)) == 32'd0))
		else $error("granted offset not aligned to block size");

	// the sweep ends before the first request is taken
	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> in_stall)
		else $error("request taken during the clearing sweep");

endmodule
